// File: sv/sve_pkg.sv
`default_nettype none

package sve_pkg;

  // Field widths.
  localparam int unsigned ValueW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW   = 3;
  localparam int unsigned StreamW = ByteW * MaxBytes;

  // Flag bits and group masks of an encoded byte.
  localparam logic [ByteW-1:0] MoreFlag = 8'h80;
  localparam logic [ByteW-1:0] NegFlag  = 8'h40;
  localparam logic [ByteW-1:0] Low6Mask = 8'h3f;
  localparam logic [ByteW-1:0] Low7Mask = 8'h7f;

  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [StreamW-1:0] stream_t;

  // Number of bytes needed for a magnitude: six bits in the first byte,
  // seven in each following byte.
  function automatic cnt_t byte_count(input logic [ValueW-1:0] mag);
    cnt_t c;
    c = cnt_t'(1);
    if (|mag[ValueW-1:6])  c = cnt_t'(2);
    if (|mag[ValueW-1:13]) c = cnt_t'(3);
    if (|mag[ValueW-1:20]) c = cnt_t'(4);
    if (|mag[ValueW-1:27]) c = cnt_t'(5);
    return c;
  endfunction

  // Builds the whole encoding, first byte in the top byte lane.
  // Lanes past the byte count are zero.
  function automatic stream_t build_stream(input logic [ValueW-1:0] mag,
                                           input logic neg,
                                           input cnt_t cnt);
    logic [33:0]      m;
    logic [ByteW-1:0] nf;
    stream_t          s;
    m  = {2'b00, mag};
    nf = neg ? NegFlag : 8'h00;
    s  = '0;
    case (cnt)
      cnt_t'(1): begin
        s[39:32] = nf | ({2'b00, m[5:0]} & Low6Mask);
      end
      cnt_t'(2): begin
        s[39:32] = MoreFlag | nf | {2'b00, m[12:7]};
        s[31:24] = {1'b0, m[6:0]} & Low7Mask;
      end
      cnt_t'(3): begin
        s[39:32] = MoreFlag | nf | {2'b00, m[19:14]};
        s[31:24] = MoreFlag | {1'b0, m[13:7]};
        s[23:16] = {1'b0, m[6:0]};
      end
      cnt_t'(4): begin
        s[39:32] = MoreFlag | nf | {2'b00, m[26:21]};
        s[31:24] = MoreFlag | {1'b0, m[20:14]};
        s[23:16] = MoreFlag | {1'b0, m[13:7]};
        s[15:8]  = {1'b0, m[6:0]};
      end
      default: begin
        s[39:32] = MoreFlag | nf | {2'b00, m[33:28]};
        s[31:24] = MoreFlag | {1'b0, m[27:21]};
        s[23:16] = MoreFlag | {1'b0, m[20:14]};
        s[15:8]  = MoreFlag | {1'b0, m[13:7]};
        s[7:0]   = {1'b0, m[6:0]};
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: sv/signed_varint_encoder_top.sv
// The first byte of an item goes through the pipeline stages and the serializer register.
// Throughput: one byte per cycle while out_stall_i is low; an item has 1 to 5 bytes.
// The serializer, which holds one item and shifts out its bytes, sets the item rate.
// Reset (rst_ni low, asynchronous) clears all stage valid bits and the byte count;
// data registers are not reset.
`default_nettype none

module signed_varint_encoder_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [sve_pkg::ValueW-1:0] value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic             [sve_pkg::ByteW-1:0]  code_byte_o,
  output logic                                  last_o
);

  // Stage valid bits.
  logic v1_q, v2_q, v3_q, v4_q;
  // Stage payloads.
  logic [sve_pkg::ValueW-1:0] raw1_q;
  logic                       neg2_q, neg3_q;
  logic [sve_pkg::ValueW-1:0] mag2_q, mag3_q;
  sve_pkg::cnt_t              cnt3_q, cnt4_q;
  sve_pkg::stream_t           strm4_q;
  // Serializer.
  sve_pkg::stream_t           ser_q, ser_d;
  sve_pkg::cnt_t              rem_q, rem_d;

  logic pop, load;
  logic adv1, adv2, adv3, adv4;
  logic rdy1, rdy2, rdy3, rdy4;

  // Output handshake and serializer load condition.
  assign pop  = out_valid_o && !out_stall_i;
  assign load = v4_q && ((rem_q == '0) || ((rem_q == sve_pkg::cnt_t'(1)) && pop));

  // Each stage moves on when it is empty or the next stage takes its item.
  assign rdy4 = !v4_q || load;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign adv1 = in_valid_i && rdy1;
  assign adv2 = v1_q && rdy2;
  assign adv3 = v2_q && rdy3;
  assign adv4 = v3_q && rdy4;

  assign in_stall_o = !rdy1;

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1 captures the input, stage 2 takes the absolute value,
  // stage 3 counts bytes, stage 4 assembles the byte stream.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      raw1_q <= value_i;
    end
    if (adv2) begin
      neg2_q <= raw1_q[sve_pkg::ValueW-1];
      mag2_q <= raw1_q[sve_pkg::ValueW-1] ? (~raw1_q + 1'b1) : raw1_q;
    end
    if (adv3) begin
      neg3_q <= neg2_q;
      mag3_q <= mag2_q;
      cnt3_q <= sve_pkg::byte_count(mag2_q);
    end
    if (adv4) begin
      cnt4_q  <= cnt3_q;
      strm4_q <= sve_pkg::build_stream(mag3_q, neg3_q, cnt3_q);
    end
  end

  // Serializer: load a new stream or shift out one byte per accepted output byte.
  always_comb begin
    ser_d = ser_q;
    rem_d = rem_q;
    if (load) begin
      ser_d = strm4_q;
      rem_d = cnt4_q;
    end else if (pop) begin
      ser_d = {ser_q[sve_pkg::StreamW-sve_pkg::ByteW-1:0], {sve_pkg::ByteW{1'b0}}};
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ser_q <= ser_d;
  end

  // Output driven straight from the serializer registers.
  assign out_valid_o = (rem_q != '0);
  assign code_byte_o = ser_q[sve_pkg::StreamW-1 -: sve_pkg::ByteW];
  assign last_o      = (rem_q == sve_pkg::cnt_t'(1));

endmodule

`default_nettype wire

// File: tb/signed_varint_encoder_top_test.sv
`timescale 1ns / 1ps

module signed_varint_encoder_top_test;

  // One expected encoded byte together with its end marker.
  typedef struct packed {
    logic [sve_pkg::ByteW-1:0] code_byte;
    logic                      last;
  } code_item_t;

  // Works out the byte encoding of every accepted value and checks the bytes that come out.
  class varint_scoreboard;
    code_item_t byte_q[$];
    int         errors;
    int         values_seen;
    int         negatives_seen;
    int         bytes_checked;
    int         len_hits[1:5];

    function new();
      errors         = 0;
      values_seen    = 0;
      negatives_seen = 0;
      bytes_checked  = 0;
      for (int k = 1; k <= 5; k++) len_hits[k] = 0;
    endfunction

    // Splits the magnitude into a six-bit top group and seven-bit groups below it.
    function void note_value(input logic [sve_pkg::ValueW-1:0] raw);
      logic                      neg;
      logic [sve_pkg::ValueW-1:0] mag;
      int                        nbytes;
      int                        sh;
      logic [63:0]               w;
      logic [sve_pkg::ByteW-1:0] b;
      code_item_t                it;
      neg    = raw[sve_pkg::ValueW-1];
      mag    = neg ? (~raw + 1'b1) : raw;
      nbytes = 1;
      while (nbytes < sve_pkg::MaxBytes && ((64'(mag) >> (6 + 7 * (nbytes - 1))) != 0))
        nbytes++;
      for (int i = 0; i < nbytes; i++) begin
        sh = 7 * (nbytes - 1 - i);
        w  = 64'(mag) >> sh;
        if (i == 0) begin
          b = w[sve_pkg::ByteW-1:0] & sve_pkg::Low6Mask;
          if (neg) b = b | sve_pkg::NegFlag;
        end else begin
          b = w[sve_pkg::ByteW-1:0] & sve_pkg::Low7Mask;
        end
        if (i < nbytes - 1) b = b | sve_pkg::MoreFlag;
        it.code_byte = b;
        it.last      = (i == nbytes - 1);
        byte_q.push_back(it);
      end
      values_seen++;
      if (neg) negatives_seen++;
      len_hits[nbytes]++;
    endfunction

    // Compares one output byte against the oldest expectation.
    function void check_byte(input logic [sve_pkg::ByteW-1:0] code_byte, input logic last);
      code_item_t want;
      if (byte_q.size() == 0) begin
        $error("unexpected byte: code_byte=%02h last=%0b", code_byte, last);
        errors++;
        return;
      end
      want = byte_q.pop_front();
      bytes_checked++;
      if (code_byte !== want.code_byte) begin
        $error("code_byte mismatch: expected %02h, actual %02h", want.code_byte, code_byte);
        errors++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return byte_q.size();
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic signed [sve_pkg::ValueW-1:0] value_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic        [sve_pkg::ByteW-1:0]  code_byte_o;
  logic                              last_o;

  varint_scoreboard board;
  int               snd_idle_pct;
  int               rcv_idle_pct;
  bit               timed_out;

  signed_varint_encoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_byte_o (code_byte_o),
    .last_o      (last_o)
  );

  // Clock with a 2 ns period.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver stalls at random on falling edges.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Every byte taken by the receiver is checked on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_byte(code_byte_o, last_o);
    end
  end

  // Offers one value, after a random gap, and holds it until it is taken.
  task automatic send_value(input logic [sve_pkg::ValueW-1:0] v);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < snd_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    board.note_value(v);
  endtask

  // Stops sending and waits until every expected byte has come out or the wait times out.
  task automatic drain_bytes();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    if (board.pending() != 0) timed_out = 1'b1;
    repeat (12) @(posedge clk_i);
  endtask

  // Picks a value of a random encoded length, with fully random words mixed in.
  function automatic logic [sve_pkg::ValueW-1:0] pick_value();
    int                         nbytes;
    int                         lo;
    int                         hi;
    logic [sve_pkg::ValueW-1:0] mag;
    if ($urandom_range(0, 9) < 2) return $urandom;
    if ($urandom_range(0, 49) == 0) return 32'h8000_0000;
    nbytes = $urandom_range(1, 5);
    if (nbytes == 1) begin
      mag = $urandom & 32'h3f;
    end else begin
      lo  = 6 + 7 * (nbytes - 2);
      hi  = (nbytes == 5) ? 30 : lo + 6;
      mag = $urandom & ((32'h1 << (hi + 1)) - 1);
      mag = mag | (32'h1 << $urandom_range(hi, lo));
    end
    return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
  endfunction

  // Directed corner values: zero, group boundaries and both ends of the range.
  logic [sve_pkg::ValueW-1:0] corner_values[] = '{
    32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_003f, 32'h0000_0040,
    32'hffff_ffc1, 32'hffff_ffc0, 32'h0000_1fff, 32'h0000_2000, 32'hffff_e000,
    32'hffff_dfff, 32'h000f_ffff, 32'h0010_0000, 32'h07ff_ffff, 32'h0800_0000,
    32'hf800_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
    32'haaaa_aaaa
  };

  initial begin
    board        = new();
    timed_out    = 1'b0;
    snd_idle_pct = 37;
    rcv_idle_pct = 57;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_i      = '0;
    out_stall_i  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (corner_values[k]) send_value(corner_values[k]);
    drain_bytes();

    // Three idling phases: receiver-heavy, then sender-heavy, then none.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 37;
          rcv_idle_pct = 57;
        end
        1: begin
          snd_idle_pct = 57;
          rcv_idle_pct = 37;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 146; n++) send_value(pick_value());
      drain_bytes();
    end

    if (timed_out) begin
      $display("Timed out with %0d bytes still expected", board.pending());
      $display("Simulation FAILED");
    end else begin
      $display("Encoded %0d values (%0d negative) and checked %0d bytes.",
               board.values_seen, board.negatives_seen, board.bytes_checked);
      $display("Values by encoded length 1..5: %0d %0d %0d %0d %0d.",
               board.len_hits[1], board.len_hits[2], board.len_hits[3],
               board.len_hits[4], board.len_hits[5]);
      if (board.errors == 0 && board.pending() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("%0d mismatches, %0d bytes never arrived", board.errors, board.pending());
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #1_000_000;
    $display("Watchdog expired");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/sve_pkg.sv
sv/signed_varint_encoder_top.sv
tb/signed_varint_encoder_top_test.sv
